### sv/lfpe_pkg.sv
package lfpe_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_NOTIFY = 2'd1,
    OP_WEAK   = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LEVEL_MAX  = 2'd0,
    REG_LEVEL_MIN  = 2'd1,
    REG_LEVEL_STEP = 2'd2
  } reg_e;

  localparam logic [7:0] LevelMaxRst  = 8'd10;
  localparam logic [7:0] LevelMinRst  = 8'd0;
  localparam logic [7:0] LevelStepRst = 8'd2;
  localparam logic [7:0] HoldRst      = 8'd3;
  localparam logic [7:0] DriveSat     = 8'd255;

  // Products at or above 256 * 255 saturate after the divide by 255
  localparam logic [23:0] SatThresh = 24'd65280;

  // One multiplier bit is consumed per cycle
  localparam int unsigned DigitCount = 8;
  localparam logic [2:0]  DigitLast  = 3'(DigitCount - 1);

  // Envelope state seen by the sequencer
  typedef struct packed {
    logic       active;
    logic [7:0] level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } env_t;

  // Divide by 255 and saturate; exact for the unsaturated range below 65280
  function automatic logic [7:0] scale_255(input logic [23:0] prod);
    logic [16:0] sum;
    sum = {1'b0, prod[15:0]} + {9'd0, prod[15:8]} + 17'd1;
    if (prod >= SatThresh) begin
      return DriveSat;
    end
    return sum[15:8];
  endfunction

endpackage

### sv/lfpe_env.sv
module lfpe_env (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             item_we_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       hold_time_i,
  output lfpe_pkg::env_t   env_o
);
  import lfpe_pkg::*;

  logic [7:0] max_q, max_d, min_q, min_d, step_q, step_d;
  logic       active_q, active_d, rising_q, rising_d;
  logic [7:0] level_q, level_d, hold_left_q, hold_left_d, hold_set_q, hold_set_d;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [8:0] rise_sum, fall_lim;

  // Work out the next envelope state
  always_comb begin
    max_d       = max_q;
    min_d       = min_q;
    step_d      = step_q;
    active_d    = active_q;
    rising_d    = rising_q;
    level_d     = level_q;
    hold_left_d = hold_left_q;
    hold_set_d  = hold_set_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    rise_sum    = {1'b0, level_q} + {1'b0, step_q};
    fall_lim    = {1'b0, min_q} + {1'b0, step_q};

    // Take register writes; unknown indexes are dropped
    if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_LEVEL_MAX:  max_d  = cfg_data_i;
        REG_LEVEL_MIN:  min_d  = cfg_data_i;
        REG_LEVEL_STEP: step_d = cfg_data_i;
        default: ;
      endcase
    end

    if (item_we_i) begin
      unique case (op_e'(op_i))
        OP_TICK: begin
          if (active_q) begin
            if (hold_left_q == 8'd0) begin
              if (rising_q) begin
                // Reach the peak: start holding
                if (rise_sum >= {1'b0, max_q}) begin
                  rising_d    = 1'b0;
                  hold_left_d = hold_set_q;
                end else begin
                  level_d = rise_sum[7:0];
                end
              end else begin
                // Reach the floor: end the pulse
                if ({1'b0, level_q} <= fall_lim) begin
                  active_d = 1'b0;
                end else begin
                  level_d = level_q - step_q;
                end
              end
            end else begin
              hold_left_d = hold_left_q - 8'd1;
            end
          end
        end
        OP_NOTIFY: begin
          red_d      = red_i;
          green_d    = green_i;
          blue_d     = blue_i;
          hold_set_d = hold_time_i;
          active_d   = 1'b1;
          rising_d   = 1'b1;
        end
        OP_WEAK: begin
          if (!active_q) begin
            red_d      = red_i;
            green_d    = green_i;
            blue_d     = blue_i;
            hold_set_d = hold_time_i;
            active_d   = 1'b1;
            rising_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= LevelMaxRst;
      min_q       <= LevelMinRst;
      step_q      <= LevelStepRst;
      active_q    <= 1'b0;
      rising_q    <= 1'b1;
      level_q     <= 8'd0;
      hold_left_q <= 8'd0;
      hold_set_q  <= HoldRst;
      red_q       <= 8'd0;
      green_q     <= 8'd0;
      blue_q      <= 8'd0;
    end else begin
      max_q       <= max_d;
      min_q       <= min_d;
      step_q      <= step_d;
      active_q    <= active_d;
      rising_q    <= rising_d;
      level_q     <= level_d;
      hold_left_q <= hold_left_d;
      hold_set_q  <= hold_set_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
    end
  end

  assign env_o.active = active_q;
  assign env_o.level  = level_q;
  assign env_o.red    = red_q;
  assign env_o.green  = green_q;
  assign env_o.blue   = blue_q;

endmodule

### sv/lfpe_smul.sv
module lfpe_smul (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [15:0] mcand_i,
  input  logic [7:0]  mplier_i,
  output logic [23:0] prod_o
);
  import lfpe_pkg::*;

  logic [23:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [7:0]  mplier_q, mplier_d;

  // Consume one multiplier bit per step: add, then shift
  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (load_i) begin
      acc_d    = 24'd0;
      mcand_d  = {8'd0, mcand_i};
      mplier_d = mplier_i;
    end else if (step_i) begin
      acc_d    = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
      mcand_d  = {mcand_q[22:0], 1'b0};
      mplier_d = {1'b0, mplier_q[7:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign prod_o = acc_q;

endmodule

### sv/led_fade_pulse_envelope_core.sv
// Notify items give no result.
// A tick while the LED is off, or the tick that ends a pulse, goes from START
// straight to FINISH; an active tick first runs two 8-step bit-serial
// multiplies (level squared, then colour lanes). No new item is taken while a
// tick is in progress; one is taken the cycle after the result is registered,
// and FINISH holds while an earlier result waits. Reset is asynchronous, active low.
module led_fade_pulse_envelope_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] hold_time_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] drive_red_o,
  output logic [7:0] drive_green_o,
  output logic [7:0] drive_blue_o,
  output logic       led_active_o
);
  import lfpe_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_START     = 6'b000010,
    ST_SQUARE    = 6'b000100,
    ST_CHAN_LOAD = 6'b001000,
    ST_CHAN      = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d, out_load;
  logic [7:0]  drive_red_q, drive_green_q, drive_blue_q;
  logic        led_active_q;
  logic        item_we, sq_load, sq_step, lane_load, lane_step;
  logic [23:0] sq_prod, red_prod, green_prod, blue_prod;
  env_t        env;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign item_we     = in_valid_i && in_ready_o;

  lfpe_env u_env (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_we_i   (item_we),
    .op_i        (op_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .hold_time_i (hold_time_i),
    .env_o       (env)
  );

  // Square the level, then scale each colour by it
  lfpe_smul u_sq (
    .clk_i    (clk_i),
    .load_i   (sq_load),
    .step_i   (sq_step),
    .mcand_i  ({8'd0, env.level}),
    .mplier_i (env.level),
    .prod_o   (sq_prod)
  );

  lfpe_smul u_red (
    .clk_i    (clk_i),
    .load_i   (lane_load),
    .step_i   (lane_step),
    .mcand_i  (sq_prod[15:0]),
    .mplier_i (env.red),
    .prod_o   (red_prod)
  );

  lfpe_smul u_green (
    .clk_i    (clk_i),
    .load_i   (lane_load),
    .step_i   (lane_step),
    .mcand_i  (sq_prod[15:0]),
    .mplier_i (env.green),
    .prod_o   (green_prod)
  );

  lfpe_smul u_blue (
    .clk_i    (clk_i),
    .load_i   (lane_load),
    .step_i   (lane_step),
    .mcand_i  (sq_prod[15:0]),
    .mplier_i (env.blue),
    .prod_o   (blue_prod)
  );

  // Sequence one tick through the multipliers; inactive ticks skip to FINISH
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sq_load   = 1'b0;
    sq_step   = 1'b0;
    lane_load = 1'b0;
    lane_step = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_we && (op_e'(op_i) == OP_TICK)) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        sq_load = 1'b1;
        cnt_d   = 3'd0;
        state_d = env.active ? ST_SQUARE : ST_FINISH;
      end
      ST_SQUARE: begin
        sq_step = 1'b1;
        cnt_d   = cnt_q + 3'd1;
        if (cnt_q == DigitLast) begin
          state_d = ST_CHAN_LOAD;
        end
      end
      ST_CHAN_LOAD: begin
        lane_load = 1'b1;
        cnt_d     = 3'd0;
        state_d   = ST_CHAN;
      end
      ST_CHAN: begin
        lane_step = 1'b1;
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == DigitLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Keep a result until its transfer completes
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Register the drive values; zeros while the LED is off
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_red_q   <= env.active ? scale_255(red_prod)   : 8'd0;
      drive_green_q <= env.active ? scale_255(green_prod) : 8'd0;
      drive_blue_q  <= env.active ? scale_255(blue_prod)  : 8'd0;
      led_active_q  <= env.active;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_red_o   = drive_red_q;
  assign drive_green_o = drive_green_q;
  assign drive_blue_o  = drive_blue_q;
  assign led_active_o  = led_active_q;

endmodule
